FILE: design/miex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS integer execute package
// Shared types, opcode codes and controller commands for the execute unit.
// ----------------------------------------------------------------------------
package miex_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_BEQL    = 6'h14;
  localparam logic [5:0] OP_BNEL    = 6'h15;
  localparam logic [5:0] OP_BLEZL   = 6'h16;
  localparam logic [5:0] OP_SPECIAL3 = 6'h1F;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;
  localparam logic [5:0] FN_EXT   = 6'h00;

  localparam logic [4:0] RT_BLTZ   = 5'h00;
  localparam logic [4:0] RT_BGEZ   = 5'h01;
  localparam logic [4:0] RT_BGEZL  = 5'h03;
  localparam logic [4:0] RT_BGEZAL = 5'h11;
  localparam logic [4:0] LinkReg   = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_DIV_FIX, ST_OUT
  } miex_state_t;

  typedef enum logic [2:0] {
    KIND_SIMPLE, KIND_MUL, KIND_MULU, KIND_DIV, KIND_DIVU
  } miex_kind_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic div_fix;
  } miex_cmd_t;

  typedef struct packed {
    miex_kind_t kind;
    logic       div_last;
  } miex_stat_t;

endpackage
`default_nettype wire

FILE: design/miex_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS integer execute controller
// Sequences simple operations, split multiplies and iterative divides.
// ----------------------------------------------------------------------------
module miex_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output miex_pkg::miex_cmd_t    cmd,
  input  wire miex_pkg::miex_stat_t stat
);
  import miex_pkg::*;

  miex_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (stat.kind)
            KIND_MUL, KIND_MULU: state_next = ST_MUL_LO;
            KIND_DIV, KIND_DIVU: state_next = ST_DIV;
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            case (stat.kind)
              KIND_MUL, KIND_MULU: state_next = ST_MUL_LO;
              KIND_DIV, KIND_DIVU: state_next = ST_DIV;
              default: state_next = ST_OUT;
            endcase
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/miex_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS integer execute datapath
// Decode, ALU, branch unit, HI/LO, split multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
module miex_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          instruction,
  input  wire logic [31:0]          source_a,
  input  wire logic [31:0]          source_b,
  input  wire logic [31:0]          fetch_address,
  input  wire miex_pkg::miex_cmd_t  cmd,
  output miex_pkg::miex_stat_t      stat,
  output logic                      write_enable,
  output logic [4:0]                write_register,
  output logic [31:0]               write_value,
  output logic                      branch_taken,
  output logic [31:0]               branch_target,
  output logic                      unsupported
);
  import miex_pkg::*;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sa;
  logic [31:0] simm, zimm, next_pc, btarget, link;
  logic [31:0] sh_sra, sh_srav;
  logic [62:0] ext_mask;
  logic        we, taken, bad;
  logic [4:0]  wr;
  logic [31:0] wv, target;
  miex_kind_t  kind;
  logic        hi_wr, lo_wr;

  logic [31:0] high_word, low_word;
  logic [31:0] ma, mb;
  logic        neg_a, neg_b;
  logic [63:0] prod_lo;
  logic [32:0] pp_cross;
  logic [31:0] rem_acc, quo;
  logic [32:0] rem_trial;
  logic [4:0]  div_cnt;
  logic        div_zero;
  logic [31:0] a_keep;
  logic [63:0] mul_full;
  logic [31:0] q_fix, r_fix;

  assign op = instruction[31:26];
  assign rt = instruction[20:16];
  assign rd = instruction[15:11];
  assign sa = instruction[10:6];
  assign fn = instruction[5:0];
  assign simm = {{16{instruction[15]}}, instruction[15:0]};
  assign zimm = {16'h0000, instruction[15:0]};
  assign next_pc = fetch_address + 32'd4;
  assign btarget = next_pc + {simm[29:0], 2'b00};
  assign link = fetch_address + 32'd8;
  assign sh_sra = 32'($signed(source_b) >>> sa);
  assign sh_srav = 32'($signed(source_b) >>> source_a[4:0]);
  assign ext_mask = (63'd1 << ({1'b0, rd} + 6'd1)) - 63'd1;

  always_comb begin
    we = 1'b0; taken = 1'b0; bad = 1'b0; wr = '0; wv = '0; target = next_pc;
    kind = KIND_SIMPLE; hi_wr = 1'b0; lo_wr = 1'b0;
    case (op)
      OP_SPECIAL: begin
        we = 1'b1; wr = rd;
        case (fn)
          FN_SLL:  wv = source_b << sa;
          FN_SRL:  wv = source_b >> sa;
          FN_SRA:  wv = sh_sra;
          FN_SLLV: wv = source_b << source_a[4:0];
          FN_SRLV: wv = source_b >> source_a[4:0];
          FN_SRAV: wv = sh_srav;
          FN_JR:   begin we = 1'b0; taken = 1'b1; target = source_a; end
          FN_JALR: begin wv = link; taken = 1'b1; target = source_a; end
          FN_MFHI: wv = high_word;
          FN_MTHI: begin we = 1'b0; hi_wr = 1'b1; end
          FN_MFLO: wv = low_word;
          FN_MTLO: begin we = 1'b0; lo_wr = 1'b1; end
          FN_MULT:  begin we = 1'b0; kind = KIND_MUL; end
          FN_MULTU: begin we = 1'b0; kind = KIND_MULU; end
          FN_DIV:   begin we = 1'b0; kind = KIND_DIV; end
          FN_DIVU:  begin we = 1'b0; kind = KIND_DIVU; end
          FN_ADD, FN_ADDU: wv = source_a + source_b;
          FN_SUB, FN_SUBU: wv = source_a - source_b;
          FN_AND:  wv = source_a & source_b;
          FN_OR:   wv = source_a | source_b;
          FN_XOR:  wv = source_a ^ source_b;
          FN_NOR:  wv = ~(source_a | source_b);
          FN_SLT:  wv = {31'd0, $signed(source_a) < $signed(source_b)};
          FN_SLTU: wv = {31'd0, source_a < source_b};
          default: begin we = 1'b0; bad = 1'b1; end
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RT_BLTZ: taken = source_a[31];
          RT_BGEZ, RT_BGEZL: taken = !source_a[31];
          RT_BGEZAL: begin
            taken = !source_a[31]; we = 1'b1; wr = LinkReg; wv = link;
          end
          default: bad = 1'b1;
        endcase
        if (taken) target = btarget;
      end
      OP_J, OP_JAL: begin
        taken = 1'b1;
        target = {next_pc[31:28], instruction[25:0], 2'b00};
        if (op == OP_JAL) begin
          we = 1'b1; wr = LinkReg; wv = link;
        end
      end
      OP_BEQ, OP_BEQL: begin
        taken = source_a == source_b; if (taken) target = btarget;
      end
      OP_BNE, OP_BNEL: begin
        taken = source_a != source_b; if (taken) target = btarget;
      end
      OP_BLEZ, OP_BLEZL: begin
        taken = (source_a == 32'd0) || source_a[31]; if (taken) target = btarget;
      end
      OP_BGTZ: begin
        taken = (source_a != 32'd0) && !source_a[31]; if (taken) target = btarget;
      end
      OP_ADDI, OP_ADDIU: begin we = 1'b1; wr = rt; wv = source_a + simm; end
      OP_SLTI: begin
        we = 1'b1; wr = rt; wv = {31'd0, $signed(source_a) < $signed(simm)};
      end
      OP_SLTIU: begin we = 1'b1; wr = rt; wv = {31'd0, source_a < simm}; end
      OP_ANDI: begin we = 1'b1; wr = rt; wv = source_a & zimm; end
      OP_ORI:  begin we = 1'b1; wr = rt; wv = source_a | zimm; end
      OP_XORI: begin we = 1'b1; wr = rt; wv = source_a ^ zimm; end
      OP_LUI:  begin we = 1'b1; wr = rt; wv = {instruction[15:0], 16'h0000}; end
      OP_SPECIAL3: begin
        if (fn == FN_EXT) begin
          we = 1'b1; wr = rt; wv = (source_a >> sa) & ext_mask[31:0];
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (!we) begin
      wr = '0; wv = '0;
    end
  end

  assign stat.kind = kind;
  assign stat.div_last = div_cnt == 5'd31;

  assign mul_full = prod_lo + {15'd0, pp_cross, 16'd0};
  assign rem_trial = {rem_acc, ma[31]} - {1'b0, mb};
  assign q_fix = (neg_a ^ neg_b) ? 32'd0 - quo : quo;
  assign r_fix = neg_a ? 32'd0 - rem_acc : rem_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_word <= '0;
      low_word <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.load) begin
        write_enable <= we; write_register <= wr; write_value <= wv;
        branch_taken <= taken; branch_target <= target; unsupported <= bad;
        if (hi_wr) high_word <= source_a;
        if (lo_wr) low_word <= source_a;
        neg_a <= ((kind == KIND_DIV) || (kind == KIND_MUL)) && source_a[31];
        neg_b <= ((kind == KIND_DIV) || (kind == KIND_MUL)) && source_b[31];
        ma <= (((kind == KIND_DIV) || (kind == KIND_MUL)) && source_a[31]) ?
              32'd0 - source_a : source_a;
        mb <= (((kind == KIND_DIV) || (kind == KIND_MUL)) && source_b[31]) ?
              32'd0 - source_b : source_b;
        a_keep <= source_a;
        div_zero <= source_b == 32'd0;
        rem_acc <= '0;
        quo <= '0;
        div_cnt <= '0;
      end
      if (cmd.mul_lo) begin
        prod_lo <= {{16'd0, ma[31:16]} * {16'd0, mb[31:16]},
                    {16'd0, ma[15:0]} * {16'd0, mb[15:0]}};
        pp_cross <= 33'({16'd0, ma[15:0]} * {16'd0, mb[31:16]}) +
                    33'({16'd0, ma[31:16]} * {16'd0, mb[15:0]});
      end
      if (cmd.mul_hi) begin
        if (neg_a ^ neg_b) begin
          {high_word, low_word} <= 64'd0 - mul_full;
        end else begin
          {high_word, low_word} <= mul_full;
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 5'd1;
        ma <= {ma[30:0], 1'b0};
        if (!rem_trial[32]) begin
          rem_acc <= rem_trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem_acc <= {rem_acc[30:0], ma[31]};
          quo <= {quo[30:0], 1'b0};
        end
      end
      if (cmd.div_fix) begin
        if (div_zero) begin
          low_word <= 32'hFFFF_FFFF; high_word <= a_keep;
        end else begin
          low_word <= q_fix; high_word <= r_fix;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/mips_integer_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS integer execute unit
// Executes the MIPS32 integer, HI/LO, jump and branch subset, one word each.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word. Ordinary instructions present
// their result in the cycle after acceptance and a new word is accepted as
// the result is taken, so with no output stall the rate is one word per cycle.
// MULT/MULTU pass through the MUL_LO and MUL_HI states of the split 16-bit
// partial-product multiplier; DIV/DIVU step the radix-2 divider, then DIV_FIX.
module mips_integer_execute_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // instruction[31:0], source_a[63:32], source_b[95:64], fetch_address[127:96]
  input  wire logic [127:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // write_enable[0], write_register[5:1], write_value[37:6], branch_taken[38],
  // branch_target[70:39], unsupported[71]
  output logic [71:0]        m_tdata
);
  import miex_pkg::*;

  miex_cmd_t  cmd;
  miex_stat_t stat;
  logic        we, bt, uns;
  logic [4:0]  wr;
  logic [31:0] wv, tgt;

  miex_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat)
  );

  miex_dp u_dp (
    .clk(clk), .rst(rst),
    .instruction(s_tdata[31:0]), .source_a(s_tdata[63:32]),
    .source_b(s_tdata[95:64]), .fetch_address(s_tdata[127:96]),
    .cmd(cmd), .stat(stat),
    .write_enable(we), .write_register(wr), .write_value(wv),
    .branch_taken(bt), .branch_target(tgt), .unsupported(uns)
  );

  assign m_tdata = {uns, tgt, bt, wv, wr, we};

endmodule
`default_nettype wire

FILE: verif/tb_mips_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the MIPS integer execute unit
// Drives instruction words with random operands through the stream input,
// predicts each result word and the HI/LO state, and checks every result.
// ----------------------------------------------------------------------------
module tb_mips_integer_execute_unit;
  import miex_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] OpLoadWord = 6'h23;

  typedef struct packed {
    logic        unsupported;
    logic [31:0] branch_target;
    logic        branch_taken;
    logic [31:0] write_value;
    logic [4:0]  write_register;
    logic        write_enable;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    exec_result_t pending[$];
    int errors;
    int checked;

    function new();
      hi_reg = '0;
      lo_reg = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void divide(logic [31:0] a, logic [31:0] b, bit signed_div);
      logic [31:0] ma, mb, q, r;
      if (b == 0) begin
        lo_reg = '1;
        hi_reg = a;
      end else if (!signed_div) begin
        lo_reg = a / b;
        hi_reg = a % b;
      end else begin
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        lo_reg = (a[31] ^ b[31]) ? -q : q;
        hi_reg = a[31] ? -r : r;
      end
    endfunction

    function void note_word(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
                            logic [31:0] pc);
      exec_result_t res;
      logic [5:0] op, fn;
      logic [4:0] rt, rd, sa;
      logic [31:0] imm, simm, nxt, bt;
      logic [63:0] p, mask;
      op = ins[31:26]; rt = ins[20:16]; rd = ins[15:11]; sa = ins[10:6];
      fn = ins[5:0];
      imm = {16'h0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      nxt = pc + 32'd4;
      bt = nxt + (simm << 2);
      res = '0;
      res.branch_target = nxt;
      case (op)
        OP_SPECIAL: begin
          res.write_enable = 1'b1;
          res.write_register = rd;
          case (fn)
            FN_SLL:  res.write_value = b << sa;
            FN_SRL:  res.write_value = b >> sa;
            FN_SRA:  res.write_value = $signed(b) >>> sa;
            FN_SLLV: res.write_value = b << a[4:0];
            FN_SRLV: res.write_value = b >> a[4:0];
            FN_SRAV: res.write_value = $signed(b) >>> a[4:0];
            FN_JR: begin
              res.write_enable = 1'b0; res.branch_taken = 1'b1;
              res.branch_target = a;
            end
            FN_JALR: begin
              res.write_value = pc + 32'd8; res.branch_taken = 1'b1;
              res.branch_target = a;
            end
            FN_MFHI: res.write_value = hi_reg;
            FN_MTHI: begin res.write_enable = 1'b0; hi_reg = a; end
            FN_MFLO: res.write_value = lo_reg;
            FN_MTLO: begin res.write_enable = 1'b0; lo_reg = a; end
            FN_MULT: begin
              res.write_enable = 1'b0;
              p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              {hi_reg, lo_reg} = p;
            end
            FN_MULTU: begin
              res.write_enable = 1'b0;
              p = {32'h0, a} * {32'h0, b};
              {hi_reg, lo_reg} = p;
            end
            FN_DIV:  begin res.write_enable = 1'b0; divide(a, b, 1'b1); end
            FN_DIVU: begin res.write_enable = 1'b0; divide(a, b, 1'b0); end
            FN_ADD, FN_ADDU: res.write_value = a + b;
            FN_SUB, FN_SUBU: res.write_value = a - b;
            FN_AND: res.write_value = a & b;
            FN_OR:  res.write_value = a | b;
            FN_XOR: res.write_value = a ^ b;
            FN_NOR: res.write_value = ~(a | b);
            FN_SLT:  res.write_value = {31'h0, $signed(a) < $signed(b)};
            FN_SLTU: res.write_value = {31'h0, a < b};
            default: begin res.write_enable = 1'b0; res.unsupported = 1'b1; end
          endcase
        end
        OP_REGIMM: begin
          case (rt)
            RT_BLTZ: res.branch_taken = a[31];
            RT_BGEZ, RT_BGEZL: res.branch_taken = !a[31];
            RT_BGEZAL: begin
              res.branch_taken = !a[31];
              res.write_enable = 1'b1; res.write_register = LinkReg;
              res.write_value = pc + 32'd8;
            end
            default: res.unsupported = 1'b1;
          endcase
          if (res.branch_taken) res.branch_target = bt;
        end
        OP_J, OP_JAL: begin
          res.branch_taken = 1'b1;
          res.branch_target = {nxt[31:28], ins[25:0], 2'b00};
          if (op == OP_JAL) begin
            res.write_enable = 1'b1; res.write_register = LinkReg;
            res.write_value = pc + 32'd8;
          end
        end
        OP_BEQ, OP_BEQL: res.branch_taken = (a == b);
        OP_BNE, OP_BNEL: res.branch_taken = (a != b);
        OP_BLEZ, OP_BLEZL: res.branch_taken = (a == 0) || a[31];
        OP_BGTZ: res.branch_taken = (a != 0) && !a[31];
        OP_ADDI, OP_ADDIU: res.write_value = a + simm;
        OP_SLTI:  res.write_value = {31'h0, $signed(a) < $signed(simm)};
        OP_SLTIU: res.write_value = {31'h0, a < simm};
        OP_ANDI: res.write_value = a & imm;
        OP_ORI:  res.write_value = a | imm;
        OP_XORI: res.write_value = a ^ imm;
        OP_LUI:  res.write_value = imm << 16;
        OP_SPECIAL3: begin
          if (fn == FN_EXT) begin
            mask = (64'd1 << ({59'h0, rd} + 64'd1)) - 64'd1;
            res.write_enable = 1'b1; res.write_register = rt;
            res.write_value = 32'(({32'h0, a >> sa}) & mask);
          end else begin
            res.unsupported = 1'b1;
          end
        end
        default: res.unsupported = 1'b1;
      endcase
      case (op)
        OP_BEQ, OP_BEQL, OP_BNE, OP_BNEL, OP_BLEZ, OP_BLEZL, OP_BGTZ:
          if (res.branch_taken) res.branch_target = bt;
        OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
          res.write_enable = 1'b1; res.write_register = rt;
        end
        default: ;
      endcase
      if (!res.write_enable) begin
        res.write_register = '0; res.write_value = '0;
      end
      pending.insert(pending.size(), res);
    endfunction

    function void check_word(exec_result_t got);
      exec_result_t exp;
      if (pending.size() == 0) begin
        $error("result word with no expectation: %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.write_enable !== exp.write_enable) begin
        $error("write_enable exp %0h got %0h", exp.write_enable, got.write_enable);
        errors++;
      end
      if (got.write_register !== exp.write_register) begin
        $error("write_register exp %0d got %0d", exp.write_register, got.write_register);
        errors++;
      end
      if (got.write_value !== exp.write_value) begin
        $error("write_value exp %h got %h", exp.write_value, got.write_value);
        errors++;
      end
      if (got.branch_taken !== exp.branch_taken) begin
        $error("branch_taken exp %0h got %0h", exp.branch_taken, got.branch_taken);
        errors++;
      end
      if (got.branch_target !== exp.branch_target) begin
        $error("branch_target exp %h got %h", exp.branch_target, got.branch_target);
        errors++;
      end
      if (got.unsupported !== exp.unsupported) begin
        $error("unsupported exp %0h got %0h", exp.unsupported, got.unsupported);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [127:0] s_tdata;
  logic [71:0] m_tdata;
  exec_scoreboard sb;
  int cycle_count;
  bit calm_window;

  mips_integer_execute_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** mips_integer_execute_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm_window || ($urandom_range(99) >= 14);
  end

  task automatic send_word(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
                           logic [31:0] pc);
    while (!calm_window && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pc, b, a, ins};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(ins, a, b, pc);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    logic [5:0] ops[24];
    logic [5:0] fns[26];
    logic [4:0] rts[4];
    logic [31:0] w;
    ops = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ,
            OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
            OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_BEQL, OP_BNEL, OP_BLEZL,
            OP_SPECIAL3, OP_SPECIAL, OP_SPECIAL};
    fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
            FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV,
            FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
            FN_NOR, FN_SLT, FN_SLTU};
    rts = '{RT_BLTZ, RT_BGEZ, RT_BGEZL, RT_BGEZAL};
    w = $urandom;
    if ($urandom_range(99) < 8) return w;
    w[31:26] = ops[$urandom_range(23)];
    if (w[31:26] == OP_SPECIAL) w[5:0] = fns[$urandom_range(25)];
    if (w[31:26] == OP_REGIMM) w[20:16] = rts[$urandom_range(3)];
    if (w[31:26] == OP_SPECIAL3 && $urandom_range(3) != 0) w[5:0] = FN_EXT;
    return w;
  endfunction

  initial begin
    logic [31:0] w;
    sb = new();
    cycle_count = 0;
    calm_window = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Read HI/LO before any write, then divide, multiply, shift and branch corner cases.
    send_word({OP_SPECIAL, 20'h0, FN_MFHI}, 0, 0, 32'h100);
    send_word({OP_SPECIAL, 20'h0, FN_MFLO}, 0, 0, 32'h104);
    send_word({OP_SPECIAL, 20'h0, FN_DIV}, 32'h1234, 0, 0);
    send_word({OP_SPECIAL, 10'h0, 5'd3, 5'd0, FN_MFLO}, 0, 0, 0);
    send_word({OP_SPECIAL, 10'h0, 5'd4, 5'd0, FN_MFHI}, 0, 0, 0);
    send_word({OP_SPECIAL, 20'h0, FN_DIV}, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_word({OP_SPECIAL, 10'h0, 5'd5, 5'd0, FN_MFLO}, 0, 0, 0);
    send_word({OP_SPECIAL, 20'h0, FN_DIVU}, 32'hFFFF_FFFF, 0, 0);
    send_word({OP_SPECIAL, 20'h0, FN_MFHI}, 0, 0, 0);
    send_word({OP_SPECIAL, 20'h0, FN_MULT}, 32'h8000_0000, 32'h8000_0000, 0);
    send_word({OP_SPECIAL, 20'h0, FN_MFHI}, 0, 0, 0);
    send_word({OP_SPECIAL, 20'h0, FN_MULTU}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word({OP_SPECIAL, 20'h0, FN_MFLO}, 0, 0, 0);
    send_word({OP_SPECIAL, 10'h0, 5'd0, 5'd31, FN_SRA}, 0, 32'h8000_0000, 0);
    send_word({OP_SPECIAL, 20'h0, FN_SRAV}, 32'hFFFF_FFE1, 32'h8000_0000, 0);
    send_word({OP_SPECIAL, 10'h0, 5'd0, 5'd0, FN_ADD}, 32'h7FFF_FFFF, 1, 0);
    send_word({OP_SPECIAL3, 5'd0, 5'd2, 5'd31, 5'd31, FN_EXT}, 32'hFFFF_FFFF, 0, 0);
    send_word({OP_SLTIU, 5'd0, 5'd1, 16'hFFFF}, 32'hFFFF_FFFE, 0, 0);
    send_word({OP_REGIMM, 5'd0, RT_BGEZAL, 16'h8000}, 32'h8000_0000, 0, 32'hFFFF_FFFC);
    send_word({OP_REGIMM, 5'd0, RT_BGEZAL, 16'h7FFF}, 0, 0, 32'h1000);
    send_word({OP_JAL, 26'h3FF_FFFF}, 0, 0, 32'hEFFF_FFFC);
    send_word({OP_SPECIAL, 20'h0, FN_JALR}, 32'hDEAD_BEEC, 0, 32'hFFFF_FFF8);
    send_word({OP_BEQL, 10'h0, 16'h0001}, 5, 5, 32'h40);
    send_word({OpLoadWord, 26'h0}, 1, 2, 32'h80);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int i = 0; i < 500; i++) begin
      calm_window = (i >= 200 && i < 300);
      w = pick_word();
      send_word(w, pick_operand(), pick_operand(), $urandom);
    end
    s_tvalid <= 1'b0;
    calm_window = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d result words over all opcodes, with random idle gaps on", sb.checked);
    $display("both sides, divide and multiply corners, and unsupported words.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** mips_integer_execute_unit: PASSED **");
    else
      $display("** mips_integer_execute_unit: FAILED **");
    $finish;
  end
endmodule
